// ----- src/bccf_pkg.sv -----
package bccf_pkg;

  // default store size
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // field widths
  localparam int CMD_W    = 2;
  localparam int COORD_W  = 10;
  localparam int RADIUS_W = 8;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 1;

  // signed width for coordinate and size compares (sizes up to 511)
  localparam int CW = 14;

  // squared-distance arithmetic
  localparam int SQ_W  = 2 * RADIUS_W;
  localparam int SUM_W = SQ_W + 2;

  localparam logic [CFG_W-1:0] RESET_SIZE = CFG_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_WIDTH  = 1'b0,
    CFG_ACTIVE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_DOT    = 2'd1,
    CMD_CIRCLE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_CIRC_INIT,
    ST_CIRC_ADJ,
    ST_CIRC_WR
  } state_t;

endpackage

// ----- src/bitmap_canvas_circle_fill_core.sv -----
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | command, x_pos, y_pos, radius, pen_color
// out     | output    | out_valid / out_stall| pixel_value, out_of_range
// cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
// the store is one row per memory word; dot, circle and clear read-modify-write whole rows, read only reads
// dot and read pass through a read state and a write state; clear reads each active row and writes it back
// circle walks all 2r+1 rows of its box, with a write state for each row that lies on the canvas
// (the row-square update and the row write share a loop)
// after reset a sweep writes zeros to all MAX_HEIGHT rows, one per cycle, before any item
// a finished result sits in the output register; the next item is taken while it waits
module bitmap_canvas_circle_fill_core #(
  parameter int MAX_WIDTH  = bccf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bccf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bccf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bccf_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bccf_pkg::CMD_W-1:0]      in_command,
  input  logic signed [bccf_pkg::COORD_W-1:0] in_x_pos,
  input  logic signed [bccf_pkg::COORD_W-1:0] in_y_pos,
  input  logic [bccf_pkg::RADIUS_W-1:0]   in_radius,
  input  logic                            in_pen_color,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_pixel_value,
  output logic                            out_out_of_range
);

  localparam int CW  = bccf_pkg::CW;
  localparam int RW  = bccf_pkg::RADIUS_W;
  localparam int SQW = bccf_pkg::SQ_W;
  localparam int SMW = bccf_pkg::SUM_W;
  localparam int AW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HCW = $clog2(MAX_HEIGHT + 1);

  bccf_pkg::state_t state_r, state_nxt;

  logic [bccf_pkg::CFG_W-1:0] cfg_width_r, cfg_height_r;

  // item registers
  bccf_pkg::cmd_t                    cmd_r, cmd_nxt;
  logic signed [bccf_pkg::COORD_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [RW-1:0]                     r_r, r_nxt;
  logic                              pen_r, pen_nxt;

  // circle walk
  logic signed [RW:0] dy_r, dy_nxt;
  logic [RW-1:0]      hw_r, hw_nxt;
  logic [SQW-1:0]     rr_r, rr_nxt, dy2_r, dy2_nxt, hw2_r, hw2_nxt;

  logic [HCW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]  init_cnt_r, init_cnt_nxt;

  logic res_pix_r, res_pix_nxt, res_oor_r, res_oor_nxt;
  logic res_pend_r, res_pend_nxt;
  logic out_valid_r, out_pix_r, out_oor_r;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [MAX_WIDTH-1:0] ram_wdata, ram_rdata, mask, merged;

  logic signed [CW-1:0] w_c, h_c, x_c, y_c, row_c, span_lo, span_hi;
  logic                 pt_inside, row_inside, grow, shrink, last_row, out_free, accept;
  logic [SMW-1:0]       sum_base;

  bccf_ram #(
    .WIDTH(MAX_WIDTH),
    .DEPTH(MAX_HEIGHT)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // effective canvas size: zero reads as one, oversize clamps to the store
  always_comb begin
    if (cfg_width_r == '0) begin
      w_c = CW'(1);
    end else if (CW'(cfg_width_r) > CW'(MAX_WIDTH)) begin
      w_c = CW'(MAX_WIDTH);
    end else begin
      w_c = $signed(CW'(cfg_width_r));
    end
    if (cfg_height_r == '0) begin
      h_c = CW'(1);
    end else if (CW'(cfg_height_r) > CW'(MAX_HEIGHT)) begin
      h_c = CW'(MAX_HEIGHT);
    end else begin
      h_c = $signed(CW'(cfg_height_r));
    end
  end

  assign x_c   = CW'(x_r);
  assign y_c   = CW'(y_r);
  assign row_c = y_c + CW'(dy_r);

  assign pt_inside  = (x_c >= 0) && (x_c < w_c) && (y_c >= 0) && (y_c < h_c);
  assign row_inside = (row_c >= 0) && (row_c < h_c);

  // row-square bookkeeping: hw is the half span of the current row
  assign sum_base = SMW'(hw2_r) + SMW'(dy2_r);
  assign grow     = (sum_base + SMW'({hw_r, 1'b1})) <= SMW'(rr_r);
  assign shrink   = sum_base > SMW'(rr_r);
  assign last_row = (dy_r == $signed({1'b0, r_r}));

  // column span of the row being written
  always_comb begin
    case (cmd_r)
      bccf_pkg::CMD_CLEAR: begin
        span_lo = '0;
        span_hi = w_c - CW'(1);
      end
      bccf_pkg::CMD_CIRCLE: begin
        span_lo = x_c - $signed(CW'(hw_r));
        span_hi = x_c + $signed(CW'(hw_r));
      end
      default: begin
        span_lo = x_c;
        span_hi = x_c;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      mask[i] = ($signed(CW'(i)) >= span_lo) && ($signed(CW'(i)) <= span_hi) &&
                ($signed(CW'(i)) < w_c);
    end
  end

  assign merged   = (ram_rdata & ~mask) | (mask & {MAX_WIDTH{pen_r}});
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != bccf_pkg::ST_IDLE) || res_pend_r;
  assign accept   = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bccf_pkg::ST_INIT: begin
        if (init_cnt_r == AW'(MAX_HEIGHT - 1)) begin
          state_nxt = bccf_pkg::ST_IDLE;
        end
      end
      bccf_pkg::ST_IDLE: begin
        if (accept) begin
          case (bccf_pkg::cmd_t'(in_command))
            bccf_pkg::CMD_CLEAR:  state_nxt = bccf_pkg::ST_CLR;
            bccf_pkg::CMD_CIRCLE: state_nxt = bccf_pkg::ST_CIRC_INIT;
            default:              state_nxt = bccf_pkg::ST_PIX_RD;
          endcase
        end
      end
      bccf_pkg::ST_CLR: begin
        if ($signed(CW'(clr_cnt_r)) == h_c) begin
          state_nxt = bccf_pkg::ST_IDLE;
        end
      end
      bccf_pkg::ST_PIX_RD:    state_nxt = bccf_pkg::ST_PIX_WR;
      bccf_pkg::ST_PIX_WR:    state_nxt = bccf_pkg::ST_IDLE;
      bccf_pkg::ST_CIRC_INIT: state_nxt = bccf_pkg::ST_CIRC_ADJ;
      bccf_pkg::ST_CIRC_ADJ: begin
        if (!grow && !shrink) begin
          if (row_inside) begin
            state_nxt = bccf_pkg::ST_CIRC_WR;
          end else if (last_row) begin
            state_nxt = bccf_pkg::ST_IDLE;
          end
        end
      end
      bccf_pkg::ST_CIRC_WR: begin
        state_nxt = last_row ? bccf_pkg::ST_IDLE : bccf_pkg::ST_CIRC_ADJ;
      end
      default: state_nxt = bccf_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_nxt      = cmd_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    r_nxt        = r_r;
    pen_nxt      = pen_r;
    dy_nxt       = dy_r;
    hw_nxt       = hw_r;
    rr_nxt       = rr_r;
    dy2_nxt      = dy2_r;
    hw2_nxt      = hw2_r;
    clr_cnt_nxt  = clr_cnt_r;
    init_cnt_nxt = init_cnt_r;
    res_pix_nxt  = res_pix_r;
    res_oor_nxt  = res_oor_r;
    res_pend_nxt = res_pend_r;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = merged;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    if (res_pend_r && out_free) begin
      res_pend_nxt = 1'b0;
    end

    case (state_r)
      bccf_pkg::ST_INIT: begin
        ram_we       = 1'b1;
        ram_waddr    = init_cnt_r;
        ram_wdata    = '0;
        init_cnt_nxt = init_cnt_r + AW'(1);
      end
      bccf_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt     = bccf_pkg::cmd_t'(in_command);
          x_nxt       = in_x_pos;
          y_nxt       = in_y_pos;
          r_nxt       = in_radius;
          pen_nxt     = in_pen_color;
          clr_cnt_nxt = '0;
          res_pix_nxt = 1'b0;
          res_oor_nxt = 1'b0;
        end
      end
      bccf_pkg::ST_CLR: begin
        // read row n while row n-1 is written back
        if ($signed(CW'(clr_cnt_r)) < h_c) begin
          ram_re    = 1'b1;
          ram_raddr = clr_cnt_r[AW-1:0];
        end
        if (clr_cnt_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(clr_cnt_r - HCW'(1));
        end
        clr_cnt_nxt = clr_cnt_r + HCW'(1);
        if ($signed(CW'(clr_cnt_r)) == h_c) begin
          res_pend_nxt = 1'b1;
        end
      end
      bccf_pkg::ST_PIX_RD: begin
        ram_re    = pt_inside;
        ram_raddr = y_c[AW-1:0];
      end
      bccf_pkg::ST_PIX_WR: begin
        ram_waddr    = y_c[AW-1:0];
        ram_we       = pt_inside && (cmd_r == bccf_pkg::CMD_DOT);
        res_oor_nxt  = !pt_inside;
        res_pix_nxt  = pt_inside && (cmd_r == bccf_pkg::CMD_READ) && ram_rdata[x_c[XW-1:0]];
        res_pend_nxt = 1'b1;
      end
      bccf_pkg::ST_CIRC_INIT: begin
        rr_nxt  = r_r * r_r;
        dy2_nxt = r_r * r_r;
        dy_nxt  = -$signed({1'b0, r_r});
        hw_nxt  = '0;
        hw2_nxt = '0;
      end
      bccf_pkg::ST_CIRC_ADJ: begin
        if (grow) begin
          hw2_nxt = SQW'(SMW'(hw2_r) + SMW'({hw_r, 1'b1}));
          hw_nxt  = hw_r + RW'(1);
        end else if (shrink) begin
          hw2_nxt = SQW'(SMW'(hw2_r) - SMW'({hw_r - RW'(1), 1'b1}));
          hw_nxt  = hw_r - RW'(1);
        end else if (row_inside) begin
          ram_re    = 1'b1;
          ram_raddr = row_c[AW-1:0];
        end else if (last_row) begin
          res_pend_nxt = 1'b1;
        end else begin
          dy2_nxt = SQW'($signed({2'b00, dy2_r}) + SMW'($signed({dy_r, 1'b1})));
          dy_nxt  = dy_r + (RW+1)'(1);
        end
      end
      bccf_pkg::ST_CIRC_WR: begin
        ram_we    = 1'b1;
        ram_waddr = row_c[AW-1:0];
        if (last_row) begin
          res_pend_nxt = 1'b1;
        end else begin
          dy2_nxt = SQW'($signed({2'b00, dy2_r}) + SMW'($signed({dy_r, 1'b1})));
          dy_nxt  = dy_r + (RW+1)'(1);
        end
      end
      default: begin
        res_pend_nxt = res_pend_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bccf_pkg::ST_INIT;
      init_cnt_r   <= '0;
      res_pend_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      cfg_width_r  <= bccf_pkg::RESET_SIZE;
      cfg_height_r <= bccf_pkg::RESET_SIZE;
    end else begin
      state_r    <= state_nxt;
      init_cnt_r <= init_cnt_nxt;
      res_pend_r <= res_pend_nxt;
      if (res_pend_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (bccf_pkg::cfg_idx_t'(cfg_index))
          bccf_pkg::CFG_ACTIVE_WIDTH:  cfg_width_r  <= cfg_wdata;
          bccf_pkg::CFG_ACTIVE_HEIGHT: cfg_height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    r_r       <= r_nxt;
    pen_r     <= pen_nxt;
    dy_r      <= dy_nxt;
    hw_r      <= hw_nxt;
    rr_r      <= rr_nxt;
    dy2_r     <= dy2_nxt;
    hw2_r     <= hw2_nxt;
    clr_cnt_r <= clr_cnt_nxt;
    res_pix_r <= res_pix_nxt;
    res_oor_r <= res_oor_nxt;
    if (res_pend_r && out_free) begin
      out_pix_r <= res_pix_r;
      out_oor_r <= res_oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_value  = out_pix_r;
  assign out_out_of_range = out_oor_r;

endmodule

// ----- src/bccf_ram.sv -----
module bccf_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- verif/tb_bitmap_canvas_circle_fill_core.sv -----
`timescale 1ns / 100ps

module tb_bitmap_canvas_circle_fill_core;

  typedef struct {
    bccf_pkg::cmd_t                      op;
    logic signed [bccf_pkg::COORD_W-1:0] x;
    logic signed [bccf_pkg::COORD_W-1:0] y;
    logic [bccf_pkg::RADIUS_W-1:0]       radius;
    logic                                pen;
  } draw_cmd_t;

  typedef struct {
    logic pixel;
    logic oor;
  } pixel_reply_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [bccf_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [bccf_pkg::CFG_W-1:0]          cfg_wdata = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [bccf_pkg::CMD_W-1:0]          in_command = '0;
  logic signed [bccf_pkg::COORD_W-1:0] in_x_pos = '0;
  logic signed [bccf_pkg::COORD_W-1:0] in_y_pos = '0;
  logic [bccf_pkg::RADIUS_W-1:0]       in_radius = '0;
  logic                                in_pen_color = 1'b0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic                                out_pixel_value;
  logic                                out_out_of_range;

  // predicted frame store, indexed [y][x]
  bit canvas_px [bccf_pkg::DEF_MAX_HEIGHT][bccf_pkg::DEF_MAX_WIDTH];
  int canvas_w = bccf_pkg::DEF_MAX_WIDTH;
  int canvas_h = bccf_pkg::DEF_MAX_HEIGHT;

  draw_cmd_t    pending_cmds[$];
  pixel_reply_t expected_pixels[$];
  draw_cmd_t    drv_cmd;
  int           cmds_in_flight = 0;
  int           mismatch_count = 0;
  bit           in_sent = 1'b1;
  int           in_wait = 0;
  int           out_hold = 0;
  bit           steady_in = 1'b0;
  bit           steady_out = 1'b0;

  // canvas size plan per random phase, -1 picks a random size
  int plan_w [8] = '{0, 511, 37, 1, 256, 257, -1, 256};
  int plan_h [8] = '{0, 511, 13, 256, 1, 100, -1, 256};

  bitmap_canvas_circle_fill_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_x_pos         (in_x_pos),
    .in_y_pos         (in_y_pos),
    .in_radius        (in_radius),
    .in_pen_color     (in_pen_color),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_value  (out_pixel_value),
    .out_out_of_range (out_out_of_range)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int usable_span(int reg_val, int limit);
    if (reg_val < 1) return 1;
    if (reg_val > limit) return limit;
    return reg_val;
  endfunction

  function automatic bit on_canvas(int x, int y);
    return x >= 0 && x < canvas_w && y >= 0 && y < canvas_h;
  endfunction

  // applies one command to the predicted store and returns its result
  function automatic pixel_reply_t paint_and_read(draw_cmd_t c);
    pixel_reply_t reply;
    int x, y, r, x0, x1, y0, y1, i, j;
    reply.pixel = 1'b0;
    reply.oor   = 1'b0;
    x = c.x;
    y = c.y;
    r = c.radius;
    case (c.op)
      bccf_pkg::CMD_CLEAR: begin
        for (j = 0; j < canvas_h; j++)
          for (i = 0; i < canvas_w; i++)
            canvas_px[j][i] = c.pen;
      end
      bccf_pkg::CMD_DOT: begin
        if (on_canvas(x, y)) canvas_px[y][x] = c.pen;
        else reply.oor = 1'b1;
      end
      bccf_pkg::CMD_CIRCLE: begin
        x0 = (x - r < 0) ? 0 : x - r;
        x1 = (x + r > canvas_w - 1) ? canvas_w - 1 : x + r;
        y0 = (y - r < 0) ? 0 : y - r;
        y1 = (y + r > canvas_h - 1) ? canvas_h - 1 : y + r;
        for (i = x0; i <= x1; i++)
          for (j = y0; j <= y1; j++)
            if ((i - x) * (i - x) + (j - y) * (j - y) <= r * r) canvas_px[j][i] = c.pen;
      end
      bccf_pkg::CMD_READ: begin
        if (on_canvas(x, y)) reply.pixel = canvas_px[y][x];
        else reply.oor = 1'b1;
      end
      default: ;
    endcase
    return reply;
  endfunction

  task automatic queue_cmd(bccf_pkg::cmd_t op, int x, int y, int r, bit pen);
    draw_cmd_t c;
    c.op     = op;
    c.x      = x[bccf_pkg::COORD_W-1:0];
    c.y      = y[bccf_pkg::COORD_W-1:0];
    c.radius = r[bccf_pkg::RADIUS_W-1:0];
    c.pen    = pen;
    cmds_in_flight++;
    pending_cmds.push_back(c);
  endtask

  // mostly on the canvas, some just around its edges, a few anywhere
  function automatic int rand_coord(int span);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return int'($urandom_range(0, span - 1));
    if (pick < 9) return ($urandom_range(0, 1) ? span : 0) + int'($urandom_range(0, 5)) - 3;
    return int'($urandom_range(0, 1023)) - 512;
  endfunction

  function automatic int rand_radius();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 15) return int'($urandom_range(0, 8));
    if (pick < 19) return int'($urandom_range(9, 40));
    return int'($urandom_range(41, 255));
  endfunction

  task automatic queue_scribbles(int budget);
    int queued, pick, cx, cy, r, dx, dy, k, n;
    bit pen;
    queued = 0;
    while (queued < budget) begin
      pick = $urandom_range(0, 99);
      pen  = 1'($urandom_range(0, 1));
      cx   = rand_coord(canvas_w);
      cy   = rand_coord(canvas_h);
      if (pick < 50) begin
        // circle, then probe its rim from both sides
        r = rand_radius();
        queue_cmd(bccf_pkg::CMD_CIRCLE, cx, cy, r, pen);
        n = $urandom_range(3, 6);
        for (k = 0; k < n; k++) begin
          dx = int'($urandom_range(0, 2 * r + 2)) - r - 1;
          dy = 0;
          while ((dy + 1) * (dy + 1) + dx * dx <= r * r) dy++;
          dy = dy + int'($urandom_range(0, 1));
          if ($urandom_range(0, 1)) dy = -dy;
          queue_cmd(bccf_pkg::CMD_READ, cx + dx, cy + dy, $urandom_range(0, 255),
                    1'($urandom_range(0, 1)));
        end
        queued += n + 1;
      end else if (pick < 65) begin
        queue_cmd(bccf_pkg::CMD_DOT, cx, cy, $urandom_range(0, 255), pen);
        queue_cmd(bccf_pkg::CMD_READ, cx, cy, $urandom_range(0, 255),
                  1'($urandom_range(0, 1)));
        queue_cmd(bccf_pkg::CMD_READ, cx + 1, cy, $urandom_range(0, 255),
                  1'($urandom_range(0, 1)));
        queued += 3;
      end else if (pick < 90) begin
        if ($urandom_range(0, 1)) begin
          queue_cmd(bccf_pkg::CMD_READ, cx, cy, $urandom_range(0, 255), pen);
        end else begin
          queue_cmd(bccf_pkg::CMD_DOT, cx, cy, $urandom_range(0, 255), pen);
        end
        queued += 1;
      end else if (pick < 93) begin
        queue_cmd(bccf_pkg::CMD_CLEAR, int'($urandom_range(0, 1023)),
                  int'($urandom_range(0, 1023)), $urandom_range(0, 255), pen);
        queued += 1;
      end else begin
        queue_cmd(bccf_pkg::CMD_CIRCLE, cx, cy, $urandom_range(0, 255), pen);
        queued += 1;
      end
    end
  endtask

  task automatic set_canvas_size(int w_reg, int h_reg);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= bccf_pkg::CFG_ACTIVE_WIDTH;
    cfg_wdata <= w_reg[bccf_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_index <= bccf_pkg::CFG_ACTIVE_HEIGHT;
    cfg_wdata <= h_reg[bccf_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    canvas_w = usable_span(w_reg, bccf_pkg::DEF_MAX_WIDTH);
    canvas_h = usable_span(h_reg, bccf_pkg::DEF_MAX_HEIGHT);
  endtask

  task automatic wait_drained(int settle);
    while (cmds_in_flight != 0 || expected_pixels.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // item driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_sent) begin
        // item still waiting for acceptance
      end else if (in_wait > 0) begin
        in_valid <= 1'b0;
        in_wait--;
      end else if (pending_cmds.size() > 0) begin
        drv_cmd      = pending_cmds.pop_front();
        in_sent      = 1'b0;
        in_valid     <= 1'b1;
        in_command   <= drv_cmd.op;
        in_x_pos     <= drv_cmd.x;
        in_y_pos     <= drv_cmd.y;
        in_radius    <= drv_cmd.radius;
        in_pen_color <= drv_cmd.pen;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_pixels.push_back(paint_and_read(drv_cmd));
      cmds_in_flight--;
      in_sent = 1'b1;
      if ($urandom_range(0, 29) == 0) steady_in = !steady_in;
      in_wait = steady_in ? 0 : $urandom_range(0, 3);
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= (out_hold > 0);
      if (out_hold > 0) out_hold--;
    end
  end

  always @(posedge clk) begin
    pixel_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: result with none pending: expected nothing, %s%0b %s%0b",
                 $time, "got pixel_value=", out_pixel_value, "out_of_range=",
                 out_out_of_range);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel_value !== want.pixel) begin
          $display("%0t: pixel_value expected %0b, got %0b", $time, want.pixel, out_pixel_value);
          mismatch_count++;
        end
        if (out_out_of_range !== want.oor) begin
          $display("%0t: out_of_range expected %0b, got %0b", $time, want.oor, out_out_of_range);
          mismatch_count++;
        end
      end
      if ($urandom_range(0, 29) == 0) steady_out = !steady_out;
      out_hold = steady_out ? 0 : $urandom_range(0, 3);
    end
  end

  initial begin
    int phase, w_reg, h_reg;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // store is zero after reset, full-size canvas
    queue_cmd(bccf_pkg::CMD_READ, 0, 0, 0, 1'b0);
    queue_cmd(bccf_pkg::CMD_READ, 255, 255, 255, 1'b1);
    queue_cmd(bccf_pkg::CMD_DOT, 0, 0, 0, 1'b1);
    queue_cmd(bccf_pkg::CMD_DOT, 255, 255, 0, 1'b1);
    queue_cmd(bccf_pkg::CMD_DOT, -1, 5, 0, 1'b1);
    queue_cmd(bccf_pkg::CMD_DOT, 256, 0, 0, 1'b1);
    queue_cmd(bccf_pkg::CMD_DOT, -512, 511, 0, 1'b1);
    queue_cmd(bccf_pkg::CMD_READ, 0, 0, 0, 1'b0);
    queue_cmd(bccf_pkg::CMD_READ, 255, 255, 0, 1'b0);
    queue_cmd(bccf_pkg::CMD_READ, -1, 0, 0, 1'b0);
    queue_cmd(bccf_pkg::CMD_READ, 0, 256, 0, 1'b0);
    queue_cmd(bccf_pkg::CMD_READ, 511, -512, 0, 1'b0);
    queue_cmd(bccf_pkg::CMD_CIRCLE, 128, 128, 0, 1'b1);
    queue_cmd(bccf_pkg::CMD_READ, 128, 128, 0, 1'b0);
    queue_cmd(bccf_pkg::CMD_READ, 129, 128, 0, 1'b0);
    // two wholly off the canvas, then one clipped on two sides at full radius
    queue_cmd(bccf_pkg::CMD_CIRCLE, -300, -300, 10, 1'b1);
    queue_cmd(bccf_pkg::CMD_CIRCLE, 511, 511, 255, 1'b1);
    queue_cmd(bccf_pkg::CMD_CIRCLE, 0, 255, 255, 1'b1);
    queue_cmd(bccf_pkg::CMD_READ, 200, 100, 0, 1'b0);
    queue_cmd(bccf_pkg::CMD_READ, 255, 0, 0, 1'b0);
    queue_cmd(bccf_pkg::CMD_CLEAR, -512, 511, 255, 1'b1);
    queue_cmd(bccf_pkg::CMD_READ, 17, 200, 0, 1'b0);
    queue_cmd(bccf_pkg::CMD_CLEAR, 0, 0, 0, 1'b0);
    queue_cmd(bccf_pkg::CMD_READ, 17, 200, 0, 1'b0);
    wait_drained(8);

    // size changes keep stored pixels, so no clear between phases
    for (phase = 0; phase < 8; phase++) begin
      w_reg = (plan_w[phase] < 0) ? int'($urandom_range(1, 256)) : plan_w[phase];
      h_reg = (plan_h[phase] < 0) ? int'($urandom_range(1, 256)) : plan_h[phase];
      set_canvas_size(w_reg, h_reg);
      @(posedge clk);
      queue_scribbles(178);
      wait_drained(8);
    end
    repeat (20) @(negedge clk);

    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
src/bccf_pkg.sv
src/bccf_ram.sv
src/bitmap_canvas_circle_fill_core.sv
verif/tb_bitmap_canvas_circle_fill_core.sv
